### rtl/core/gift_pkg.sv
// gift_pkg: shared types, constants and round functions for the gift-128 cipher
// no dependencies; used by the round stage, the config block and the top level
package gift_pkg;

  localparam int unsigned ROUNDS_DEFAULT = 40;
  localparam int unsigned ROUNDS_MAX     = 40;

  localparam logic REG_KEY_HIGH = 1'b0;
  localparam logic REG_KEY_LOW  = 1'b1;

  localparam logic [31:0] RC_TOP_BIT = 32'h8000_0000;

  typedef struct packed {
    logic        op;
    logic [31:0] s0;
    logic [31:0] s1;
    logic [31:0] s2;
    logic [31:0] s3;
  } blk_t;

  typedef struct packed {
    logic [31:0] k2;
    logic [31:0] k1;
  } rkey_t;

  function automatic logic [15:0] ror16(input logic [15:0] x, input int unsigned n);
    logic [31:0] d;
    d = {x, x} >> n;
    return d[15:0];
  endfunction

  // key words after r rotations, then the two round key halves
  function automatic rkey_t round_key(input logic [127:0] key, input int unsigned r);
    logic [127:0] kv;
    rkey_t        rk;
    kv = key;
    for (int unsigned i = 0; i < ROUNDS_MAX; i++) begin
      if (i < r) begin
        kv = {ror16(kv[31:16], 2), ror16(kv[15:0], 12), kv[127:32]};
      end
    end
    rk.k2 = kv[95:64];
    rk.k1 = kv[31:0];
    return rk;
  endfunction

  function automatic logic [5:0] round_const(input int unsigned r);
    logic [5:0] c;
    c = 6'd0;
    for (int unsigned i = 0; i < ROUNDS_MAX; i++) begin
      if (i <= r) begin
        c = {c[4:0], c[5] ^ c[4] ^ 1'b1};
      end
    end
    return c;
  endfunction

  function automatic logic [31:0] slice_perm(input logic [31:0] s, input int unsigned p0,
                                             input int unsigned p1, input int unsigned p2,
                                             input int unsigned p3);
    logic [31:0] t;
    t = '0;
    for (int unsigned b = 0; b < 8; b++) begin
      t[b + 8 * p0] = s[4 * b];
      t[b + 8 * p1] = s[4 * b + 1];
      t[b + 8 * p2] = s[4 * b + 2];
      t[b + 8 * p3] = s[4 * b + 3];
    end
    return t;
  endfunction

  function automatic logic [31:0] slice_unperm(input logic [31:0] s, input int unsigned p0,
                                               input int unsigned p1, input int unsigned p2,
                                               input int unsigned p3);
    logic [31:0] t;
    t = '0;
    for (int unsigned b = 0; b < 8; b++) begin
      t[4 * b]     = s[b + 8 * p0];
      t[4 * b + 1] = s[b + 8 * p1];
      t[4 * b + 2] = s[b + 8 * p2];
      t[4 * b + 3] = s[b + 8 * p3];
    end
    return t;
  endfunction

  function automatic blk_t enc_round(input blk_t x, input rkey_t rk, input logic [5:0] rc);
    logic [31:0] s0, s1, s2, s3, t;
    blk_t        y;
    s0 = x.s0;
    s1 = x.s1;
    s2 = x.s2;
    s3 = x.s3;
    s1 = s1 ^ (s0 & s2);
    s0 = s0 ^ (s1 & s3);
    s2 = s2 ^ (s0 | s1);
    s3 = s3 ^ s2;
    s1 = s1 ^ s3;
    s3 = ~s3;
    s2 = s2 ^ (s0 & s1);
    t  = s0;
    s0 = s3;
    s3 = t;
    y.op = x.op;
    y.s0 = slice_perm(s0, 0, 3, 2, 1);
    y.s1 = slice_perm(s1, 1, 0, 3, 2) ^ rk.k1;
    y.s2 = slice_perm(s2, 2, 1, 0, 3) ^ rk.k2;
    y.s3 = slice_perm(s3, 3, 2, 1, 0) ^ RC_TOP_BIT ^ {26'd0, rc};
    return y;
  endfunction

  function automatic blk_t dec_round(input blk_t x, input rkey_t rk, input logic [5:0] rc);
    logic [31:0] s0, s1, s2, s3, t;
    blk_t        y;
    s0 = slice_unperm(x.s0, 0, 3, 2, 1);
    s1 = slice_unperm(x.s1 ^ rk.k1, 1, 0, 3, 2);
    s2 = slice_unperm(x.s2 ^ rk.k2, 2, 1, 0, 3);
    s3 = slice_unperm(x.s3 ^ RC_TOP_BIT ^ {26'd0, rc}, 3, 2, 1, 0);
    t  = s0;
    s0 = s3;
    s3 = t;
    s2 = s2 ^ (s0 & s1);
    s3 = ~s3;
    s1 = s1 ^ s3;
    s3 = s3 ^ s2;
    s2 = s2 ^ (s0 | s1);
    s0 = s0 ^ (s1 & s3);
    s1 = s1 ^ (s0 & s2);
    y.op = x.op;
    y.s0 = s0;
    y.s1 = s1;
    y.s2 = s2;
    y.s3 = s3;
    return y;
  endfunction

endpackage

### rtl/core/gift_in_if.sv
// gift_in_if: input channel carrying one block transaction (op and 128-bit block)
// no dependencies
interface gift_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [63:0] block_high;
  logic [63:0] block_low;

  modport source (output valid, output op, output block_high, output block_low, input ready);
  modport sink (input valid, input op, input block_high, input block_low, output ready);
endinterface

### rtl/core/gift_out_if.sv
// gift_out_if: output channel carrying one result transaction (128-bit block)
// no dependencies
interface gift_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_high;
  logic [63:0] result_low;

  modport source (output valid, output result_high, output result_low, input ready);
  modport sink (input valid, input result_high, input result_low, output ready);
endinterface

### rtl/core/gift_cfg.sv
// gift_cfg: apb-style key register file, two 64-bit key registers
// depends on gift_pkg for register index codes
module gift_cfg (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  output logic [63:0] key_high,
  output logic [63:0] key_low
);
  import gift_pkg::*;

  logic wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (wr_en && pready) begin
      unique case (paddr[3])
        REG_KEY_HIGH: key_high <= pwdata;
        REG_KEY_LOW:  key_low  <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      REG_KEY_HIGH: prdata = key_high;
      REG_KEY_LOW:  prdata = key_low;
    endcase
  end

endmodule

### rtl/core/gift_round.sv
// gift_round: one pipeline stage, one encrypt or decrypt round followed by a register
// depends on gift_pkg for the block type and round functions
module gift_round #(
  parameter int unsigned ROUND_COUNT = gift_pkg::ROUNDS_DEFAULT,
  parameter int unsigned ROUND_IDX   = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [127:0]   key,
  input  logic           up_valid,
  output logic           up_ready,
  input  gift_pkg::blk_t up_blk,
  output logic           dn_valid,
  input  logic           dn_ready,
  output gift_pkg::blk_t dn_blk
);
  import gift_pkg::*;

  localparam int unsigned DEC_IDX = ROUND_COUNT - 1 - ROUND_IDX;
  localparam logic [5:0]  RC_ENC  = round_const(ROUND_IDX);
  localparam logic [5:0]  RC_DEC  = round_const(DEC_IDX);

  rkey_t rk_enc;
  rkey_t rk_dec;
  blk_t  blk_next;

  assign rk_enc   = round_key(key, ROUND_IDX);
  assign rk_dec   = round_key(key, DEC_IDX);
  assign blk_next = up_blk.op ? dec_round(up_blk, rk_dec, RC_DEC)
                              : enc_round(up_blk, rk_enc, RC_ENC);
  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_blk <= blk_next;
    end
  end

endmodule

### rtl/core/gift128_block_cipher.sv
// gift128_block_cipher: gift-128 encrypt/decrypt engine, one round per pipeline stage.
// A block transaction enters an input register, then passes ROUND_COUNT round stages,
// each holding one full round; one block per cycle is taken in steady state while the
// output is ready. Encrypt and decrypt blocks may be mixed freely. Every stage has its
// own valid bit and fills bubbles, so a stalled output holds its result while earlier
// stages fill gaps. Keys are written over the apb port (key_high at 0x0, key_low at 0x8)
// by the user, who must do so only while idle; the block itself does not enforce it.
// depends on gift_pkg, gift_in_if, gift_out_if, gift_cfg and gift_round
module gift128_block_cipher #(
  parameter int unsigned ROUND_COUNT = gift_pkg::ROUNDS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  gift_in_if.sink     data_in,
  gift_out_if.source  data_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import gift_pkg::*;

  logic [63:0]        key_high;
  logic [63:0]        key_low;
  logic [ROUND_COUNT:0] vld;
  logic [ROUND_COUNT:0] up_rdy;
  blk_t               blk [ROUND_COUNT+1];
  logic               in_rdy;
  logic               in_vld;
  blk_t               in_blk;

  gift_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .key_high (key_high),
    .key_low  (key_low)
  );

  // input register
  assign in_rdy        = !in_vld || up_rdy[0];
  assign data_in.ready = in_rdy;
  assign vld[0]        = in_vld;
  assign blk[0]        = in_blk;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_rdy) begin
      in_vld <= data_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && data_in.valid) begin
      in_blk <= '{op: data_in.op, s0: data_in.block_high[63:32], s1: data_in.block_high[31:0],
                  s2: data_in.block_low[63:32], s3: data_in.block_low[31:0]};
    end
  end

  for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_round
    gift_round #(
      .ROUND_COUNT (ROUND_COUNT),
      .ROUND_IDX   (g)
    ) u_round (
      .clk      (clk),
      .rst      (rst),
      .key      ({key_high, key_low}),
      .up_valid (vld[g]),
      .up_ready (up_rdy[g]),
      .up_blk   (blk[g]),
      .dn_valid (vld[g+1]),
      .dn_ready (up_rdy[g+1]),
      .dn_blk   (blk[g+1])
    );
  end

  assign up_rdy[ROUND_COUNT]  = data_out.ready;
  assign data_out.valid       = vld[ROUND_COUNT];
  assign data_out.result_high = {blk[ROUND_COUNT].s0, blk[ROUND_COUNT].s1};
  assign data_out.result_low  = {blk[ROUND_COUNT].s2, blk[ROUND_COUNT].s3};

  a_reset_empty: assert property (@(posedge clk) rst |=> !data_out.valid && !vld[0])
    else $error("pipeline not empty after reset");

  a_no_stall_when_drained: assert property (@(posedge clk) disable iff (rst)
    data_out.ready |-> data_in.ready)
    else $error("input stalled while output drains");

  a_key_write: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && (paddr[3] == REG_KEY_LOW) |=> key_low == $past(pwdata))
    else $error("key_low write lost");

endmodule

### tb/sv/tb_top.sv
// tb_top: self-checking bench for gift128_block_cipher, encrypt and decrypt under several keys
// drives gift_in_if / gift_out_if and the apb key port, checks every result against a local model
// depends on gift_pkg, gift_in_if, gift_out_if and the gift128_block_cipher rtl
module tb_top;
  import gift_pkg::*;

  localparam int unsigned NROUNDS = ROUNDS_DEFAULT;
  localparam int unsigned LATENCY = NROUNDS + 1;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned PHASE_ITEMS = 170;
  localparam int unsigned CALM_ITEMS = 100;
  localparam logic OP_ENC = 1'b0;
  localparam logic OP_DEC = 1'b1;
  localparam logic [7:0] LANES_S0 = {2'd1, 2'd2, 2'd3, 2'd0};
  localparam logic [7:0] LANES_S1 = {2'd2, 2'd3, 2'd0, 2'd1};
  localparam logic [7:0] LANES_S2 = {2'd3, 2'd0, 2'd1, 2'd2};
  localparam logic [7:0] LANES_S3 = {2'd0, 2'd1, 2'd2, 2'd3};
  localparam logic [63:0] ONES = 64'hffff_ffff_ffff_ffff;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } block_t;

  typedef struct packed {
    logic        op;
    logic [63:0] hi;
    logic [63:0] lo;
  } vector_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  gift_in_if  in_if ();
  gift_out_if out_if ();

  gift128_block_cipher #(
    .ROUND_COUNT(NROUNDS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .data_in(in_if),
    .data_out(out_if),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  block_t      awaited_blocks[$];
  int unsigned fail_count = 0;
  bit          calm = 1'b0;
  logic [31:0] sched_k2[NROUNDS];
  logic [31:0] sched_k1[NROUNDS];
  logic [5:0]  sched_rc[NROUNDS];
  block_t      last_cipher;
  block_t      last_plain;

  vector_t directed_rows[12] = '{
    '{OP_ENC, 64'h0, 64'h0},
    '{OP_ENC, ONES, ONES},
    '{OP_DEC, 64'h0, 64'h0},
    '{OP_DEC, ONES, ONES},
    '{OP_ENC, ONES, 64'h0},
    '{OP_DEC, 64'h0, ONES},
    '{OP_ENC, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001},
    '{OP_DEC, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001},
    '{OP_ENC, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555},
    '{OP_DEC, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa},
    '{OP_ENC, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210},
    '{OP_DEC, 64'h0000_0001_0000_0001, 64'h8000_0000_8000_0000}
  };

  function automatic logic [31:0] slice_scatter(input logic [31:0] s, input logic [7:0] lanes);
    logic [31:0] t;
    t = '0;
    for (int b = 0; b < 8; b++) begin
      for (int j = 0; j < 4; j++) begin
        t[b + 8 * lanes[2 * j +: 2]] = s[4 * b + j];
      end
    end
    return t;
  endfunction

  function automatic logic [31:0] slice_gather(input logic [31:0] s, input logic [7:0] lanes);
    logic [31:0] t;
    t = '0;
    for (int b = 0; b < 8; b++) begin
      for (int j = 0; j < 4; j++) begin
        t[4 * b + j] = s[b + 8 * lanes[2 * j +: 2]];
      end
    end
    return t;
  endfunction

  task automatic load_schedule(input logic [127:0] key);
    logic [15:0] w[8];
    logic [15:0] a;
    logic [15:0] b;
    logic [5:0]  c;
    for (int i = 0; i < 8; i++) begin
      w[i] = key[127 - 16 * i -: 16];
    end
    c = 6'd0;
    for (int r = 0; r < NROUNDS; r++) begin
      sched_k2[r] = {w[2], w[3]};
      sched_k1[r] = {w[6], w[7]};
      c = {c[4:0], c[5] ^ c[4] ^ 1'b1};
      sched_rc[r] = c;
      a = (w[6] >> 2) | (w[6] << 14);
      b = (w[7] >> 12) | (w[7] << 4);
      for (int i = 7; i >= 2; i--) begin
        w[i] = w[i - 2];
      end
      w[1] = b;
      w[0] = a;
    end
  endtask

  function automatic block_t gift_cipher(input logic op, input block_t blk);
    logic [31:0] s0, s1, s2, s3, t;
    block_t      res;
    s0 = blk.hi[63:32];
    s1 = blk.hi[31:0];
    s2 = blk.lo[63:32];
    s3 = blk.lo[31:0];
    if (op == OP_ENC) begin
      for (int r = 0; r < NROUNDS; r++) begin
        s1 ^= s0 & s2;
        s0 ^= s1 & s3;
        s2 ^= s0 | s1;
        s3 ^= s2;
        s1 ^= s3;
        s3 = ~s3;
        s2 ^= s0 & s1;
        t = s0;
        s0 = s3;
        s3 = t;
        s0 = slice_scatter(s0, LANES_S0);
        s1 = slice_scatter(s1, LANES_S1) ^ sched_k1[r];
        s2 = slice_scatter(s2, LANES_S2) ^ sched_k2[r];
        s3 = slice_scatter(s3, LANES_S3) ^ 32'h8000_0000 ^ {26'd0, sched_rc[r]};
      end
    end else begin
      for (int r = NROUNDS - 1; r >= 0; r--) begin
        s0 = slice_gather(s0, LANES_S0);
        s1 = slice_gather(s1 ^ sched_k1[r], LANES_S1);
        s2 = slice_gather(s2 ^ sched_k2[r], LANES_S2);
        s3 = slice_gather(s3 ^ 32'h8000_0000 ^ {26'd0, sched_rc[r]}, LANES_S3);
        t = s0;
        s0 = s3;
        s3 = t;
        s2 ^= s0 & s1;
        s3 = ~s3;
        s1 ^= s3;
        s3 ^= s2;
        s2 ^= s0 | s1;
        s0 ^= s1 & s3;
        s1 ^= s0 & s2;
      end
    end
    res.hi = {s0, s1};
    res.lo = {s2, s3};
    return res;
  endfunction

  task automatic apb_write(input logic [3:0] addr, input logic [63:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic program_key(input logic [63:0] khi, input logic [63:0] klo);
    while (awaited_blocks.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    apb_write({REG_KEY_HIGH, 3'b000}, khi);
    apb_write({REG_KEY_LOW, 3'b000}, klo);
    load_schedule({khi, klo});
  endtask

  task automatic send_block(input vector_t v);
    block_t blk;
    block_t res;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.op         <= v.op;
    in_if.block_high <= v.hi;
    in_if.block_low  <= v.lo;
    do @(posedge clk); while (!in_if.ready);
    blk.hi = v.hi;
    blk.lo = v.lo;
    res = gift_cipher(v.op, blk);
    awaited_blocks.push_back(res);
    if (v.op == OP_ENC) begin
      last_cipher = res;
    end else begin
      last_plain = res;
    end
  endtask

  function automatic logic [63:0] pick_word();
    logic [63:0] w;
    case ($urandom_range(0, 7))
      0: w = 64'h0;
      1: w = ONES;
      2: w = 64'h1 << $urandom_range(0, 63);
      3: w = ~(64'h1 << $urandom_range(0, 63));
      default: w = {$urandom, $urandom};
    endcase
    return w;
  endfunction

  task automatic run_random(input int unsigned count, input bit calm_tail);
    vector_t v;
    for (int unsigned n = 0; n < count; n++) begin
      if (calm_tail && n + CALM_ITEMS >= count) begin
        calm = 1'b1;
      end
      case ($urandom_range(0, 9))
        0: v = '{OP_DEC, last_cipher.hi, last_cipher.lo};
        1: v = '{OP_ENC, last_plain.hi, last_plain.lo};
        default: v = '{logic'($urandom_range(0, 1)), pick_word(), pick_word()};
      endcase
      send_block(v);
    end
    in_if.valid <= 1'b0;
  endtask

  always begin
    out_if.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 4) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    block_t want;
    if (!rst && out_if.valid && out_if.ready) begin
      if (awaited_blocks.size() == 0) begin
        $error("unexpected result transaction: result_high %h result_low %h",
               out_if.result_high, out_if.result_low);
        fail_count++;
      end else begin
        want = awaited_blocks.pop_front();
        if (out_if.result_high !== want.hi) begin
          $error("result_high: expected %h, actual %h", want.hi, out_if.result_high);
          fail_count++;
        end
        if (out_if.result_low !== want.lo) begin
          $error("result_low: expected %h, actual %h", want.lo, out_if.result_low);
          fail_count++;
        end
      end
    end
  end

  always begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (psel && penable)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst              <= 1'b1;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    in_if.valid      <= 1'b0;
    in_if.op         <= OP_ENC;
    in_if.block_high <= '0;
    in_if.block_low  <= '0;
    last_cipher = '0;
    last_plain  = '0;
    load_schedule('0);
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // key never written: all-zero key
    foreach (directed_rows[i]) send_block(directed_rows[i]);
    in_if.valid <= 1'b0;
    program_key(ONES, ONES);
    foreach (directed_rows[i]) send_block(directed_rows[i]);
    in_if.valid <= 1'b0;

    program_key({$urandom, $urandom}, {$urandom, $urandom});
    run_random(PHASE_ITEMS, 1'b0);
    program_key(64'h0, ONES);
    run_random(PHASE_ITEMS, 1'b0);
    program_key(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
    run_random(PHASE_ITEMS, 1'b0);
    program_key(ONES, 64'h0);
    run_random(PHASE_ITEMS, 1'b0);
    program_key({$urandom, $urandom}, {$urandom, $urandom});
    run_random(PHASE_ITEMS, 1'b0);
    program_key({$urandom, $urandom}, {$urandom, $urandom});
    run_random(PHASE_ITEMS, 1'b1);

    while (awaited_blocks.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/gift_pkg.sv
rtl/core/gift_in_if.sv
rtl/core/gift_out_if.sv
rtl/core/gift_cfg.sv
rtl/core/gift_round.sv
rtl/core/gift128_block_cipher.sv
tb/sv/tb_top.sv
